### src/dttd_pkg.sv
package dttd_pkg;

    // character codes
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_POINT   = 8'h2E;
    localparam logic [7:0] CH_EXP_UC  = 8'h45;
    localparam logic [7:0] CH_EXP_LC  = 8'h65;
    localparam logic [7:0] CH_IGNORE  = 8'h63;
    localparam logic [8:0] CH_ZERO    = 9'd48;
    localparam logic [3:0] RADIX      = 4'd10;

    // binary64 layout and working exponent range (value = m * 2^e)
    localparam logic [10:0]        EXP_ALL_ONES = 11'h7FF;
    localparam logic signed [12:0] EXP_MIN      = -13'sd1075;
    localparam logic signed [12:0] EXP_SUBNORM  = -13'sd1074;
    localparam logic signed [12:0] EXP_BIAS     = 13'sd1075;
    localparam logic signed [12:0] EXP_PACK     = 13'sd1076;
    localparam logic signed [12:0] EXP_FIELD_MAX = 13'sd2047;
    localparam logic signed [12:0] ALIGN_GUARD  = 13'sd10;
    localparam logic signed [12:0] DIV_GUARD    = 13'sd8;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_MUL     = 9'b000000010,
        ST_ALIGN   = 9'b000000100,
        ST_ADDSUB  = 9'b000001000,
        ST_NORM    = 9'b000010000,
        ST_SCALE   = 9'b000100000,
        ST_DIV     = 9'b001000000,
        ST_DIV_FIN = 9'b010000000,
        ST_OUT     = 9'b100000000
    } dttd_state_t;

    typedef enum logic [2:0] {
        OP_DIGIT_MUL = 3'b001,
        OP_DIGIT_ADD = 3'b010,
        OP_SCALE     = 3'b100
    } dttd_op_t;

    typedef struct packed {
        logic char_take;
        logic end_take;
        logic mul_load;
        logic align;
        logic addsub;
        logic div_load;
        logic div_step;
        logic div_finish;
        logic norm_step;
        logic pack;
        logic count_dec;
        logic out_load;
    } dttd_cmd_t;

    typedef struct packed {
        logic mant_digit;
        logic end_item;
        logic norm_done;
        logic div_last;
        logic count_zero;
        logic acc_special;
        logic scale_up;
        logic out_full;
    } dttd_sts_t;

endpackage

### src/decimal_text_to_double_core.sv
// Decimal text to binary64 converter.
// Input channel (in_valid/in_ready): one item per character in ch, or an end
// item with end_of_string high. Output channel (out_valid/out_ready): one
// result_bits item per end item, the IEEE binary64 pattern of the number.
// Work per item, done on the shared float unit and its normaliser:
//   marker or exponent character: taken directly while idle.
//   mantissa digit: x10, round, align, add, round; the
//   normaliser moves one or eight places a cycle.
//   end item: for each power of ten, a multiply by ten or a divide
//   by ten in radix-256 divider steps, each followed by a round;
//   scaling stops early once the value is zero or infinite.
// Items are taken one at a time; in_ready is high only while idle.
// The result sits in an output register: a stalled receiver does not stop
// character items, only the next result waits until the register frees.
// Reset: asynchronous, active low; clears the accumulator to +0.0, both
// exponents, all flags and the output valid. Loading a result clears all but the output valid, which it sets.
module decimal_text_to_double_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_bits
);

    // command and status between sequencer and float datapath
    dttd_pkg::dttd_cmd_t cmd;
    dttd_pkg::dttd_sts_t sts;

    dttd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dttd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ch            (ch),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_bits   (result_bits),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

### src/dttd_ctrl.sv
module dttd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dttd_pkg::dttd_sts_t sts,
    output dttd_pkg::dttd_cmd_t cmd
);

    dttd_pkg::dttd_state_t state_reg, state_next;
    dttd_pkg::dttd_op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dttd_pkg::ST_IDLE;
            op_reg    <= dttd_pkg::OP_SCALE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_ready = (state_reg == dttd_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        unique case (state_reg)
            dttd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.end_item)
                    begin
                        cmd.end_take = 1'b1;
                        state_next   = dttd_pkg::ST_SCALE;
                    end
                    else
                    begin
                        cmd.char_take = 1'b1;
                        if (sts.mant_digit)
                            state_next = dttd_pkg::ST_MUL;
                    end
                end
            end
            dttd_pkg::ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                op_next      = dttd_pkg::OP_DIGIT_MUL;
                state_next   = dttd_pkg::ST_NORM;
            end
            dttd_pkg::ST_NORM:
            begin
                if (sts.norm_done)
                begin
                    cmd.pack = 1'b1;
                    unique case (op_reg)
                        dttd_pkg::OP_DIGIT_MUL: state_next = dttd_pkg::ST_ALIGN;
                        dttd_pkg::OP_DIGIT_ADD: state_next = dttd_pkg::ST_IDLE;
                        default:                state_next = dttd_pkg::ST_SCALE;
                    endcase
                end
                else
                    cmd.norm_step = 1'b1;
            end
            dttd_pkg::ST_ALIGN:
            begin
                cmd.align  = 1'b1;
                state_next = dttd_pkg::ST_ADDSUB;
            end
            dttd_pkg::ST_ADDSUB:
            begin
                cmd.addsub = 1'b1;
                op_next    = dttd_pkg::OP_DIGIT_ADD;
                state_next = dttd_pkg::ST_NORM;
            end
            dttd_pkg::ST_SCALE:
            begin
                if (sts.count_zero || sts.acc_special)
                    state_next = dttd_pkg::ST_OUT;
                else if (sts.scale_up)
                begin
                    cmd.mul_load  = 1'b1;
                    cmd.count_dec = 1'b1;
                    op_next       = dttd_pkg::OP_SCALE;
                    state_next    = dttd_pkg::ST_NORM;
                end
                else
                begin
                    cmd.div_load  = 1'b1;
                    cmd.count_dec = 1'b1;
                    state_next    = dttd_pkg::ST_DIV;
                end
            end
            dttd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = dttd_pkg::ST_DIV_FIN;
            end
            dttd_pkg::ST_DIV_FIN:
            begin
                cmd.div_finish = 1'b1;
                op_next        = dttd_pkg::OP_SCALE;
                state_next     = dttd_pkg::ST_NORM;
            end
            dttd_pkg::ST_OUT:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = dttd_pkg::ST_IDLE;
                end
            end
            default: state_next = dttd_pkg::ST_IDLE;
        endcase
    end

    // quotient is only taken after a divide pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dttd_pkg::ST_DIV_FIN) |-> $past(state_reg == dttd_pkg::ST_DIV))
        else $error("divide finish without divide pass");

endmodule

### src/dttd_datapath.sv
module dttd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          ch,
    input  logic                end_of_string,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         result_bits,
    input  dttd_pkg::dttd_cmd_t cmd,
    output dttd_pkg::dttd_sts_t sts
);

    // architectural state
    logic [63:0]        acc_reg;
    logic [15:0]        frac_exp_reg;
    logic [15:0]        wr_exp_reg;
    logic               in_exp_reg, in_frac_reg, neg_reg, exp_neg_reg;
    logic signed [8:0]  digit_reg;
    logic [15:0]        count_reg;
    logic               up_reg;
    // working float
    logic [63:0]        m_reg;
    logic signed [12:0] e_reg;
    logic               sticky_reg, sign_reg, pass_reg;
    logic [63:0]        a_reg, b_reg;
    logic               sa_reg, sb_reg;
    // divider
    logic [63:0]        n_reg;
    logic [3:0]         rem_reg;
    logic [2:0]         chunk_reg;
    // output
    logic [63:0]        result_reg;
    logic               out_valid_reg;

    // unpack accumulator
    logic [10:0]        acc_field;
    logic               acc_zero, acc_inf;
    logic [52:0]        q;
    logic [63:0]        q64;
    logic signed [12:0] eq;

    assign acc_field = acc_reg[62:52];
    assign acc_zero  = (acc_reg[62:0] == 63'd0);
    assign acc_inf   = (acc_field == dttd_pkg::EXP_ALL_ONES);
    assign q         = {(acc_field != 11'd0), acc_reg[51:0]};
    assign q64       = {11'd0, q};
    assign eq        = (acc_field == 11'd0) ? dttd_pkg::EXP_SUBNORM
                       : $signed({2'b00, acc_field}) - dttd_pkg::EXP_BIAS;

    // character decode
    logic is_minus, is_point, is_exp, is_other;
    logic signed [8:0] digit9;
    logic [15:0] d16, wr_x10, total;

    assign is_minus = (ch == dttd_pkg::CH_MINUS);
    assign is_point = (ch == dttd_pkg::CH_POINT);
    assign is_exp   = (ch == dttd_pkg::CH_EXP_UC) || (ch == dttd_pkg::CH_EXP_LC);
    assign is_other = !is_minus && !is_point && !is_exp && (ch != dttd_pkg::CH_IGNORE);
    assign digit9   = $signed({1'b0, ch} - dttd_pkg::CH_ZERO);
    assign d16      = {{7{digit9[8]}}, digit9};
    assign wr_x10   = (wr_exp_reg << 3) + (wr_exp_reg << 1);
    assign total    = frac_exp_reg + wr_exp_reg;

    // alignment for the digit add
    logic [63:0]        a_al, b_al;
    logic signed [12:0] e_al;
    logic               sd_al;
    always_comb
    begin
        logic [8:0]         dneg;
        logic [7:0]         dmag;
        logic signed [12:0] sh_l, sh_r;
        logic [7:0]         lost_mask;
        dneg  = -digit_reg;
        dmag  = digit_reg[8] ? dneg[7:0] : digit_reg[7:0];
        sd_al = digit_reg[8];
        sh_l  = -eq;
        sh_r  = eq - dttd_pkg::ALIGN_GUARD;
        lost_mask = (8'd1 << sh_r[2:0]) - 8'd1;
        if (acc_zero)
        begin
            a_al = 64'd0;
            b_al = {56'd0, dmag};
            e_al = 13'sd0;
        end
        else if (eq <= 13'sd0)
        begin
            a_al = q64;
            b_al = {56'd0, dmag} << sh_l[5:0];
            e_al = eq;
        end
        else if (eq <= dttd_pkg::ALIGN_GUARD)
        begin
            a_al = q64 << eq[3:0];
            b_al = {56'd0, dmag};
            e_al = 13'sd0;
        end
        else
        begin
            a_al = q64 << dttd_pkg::ALIGN_GUARD[3:0];
            e_al = sh_r;
            if (sh_r >= 13'sd8)
                b_al = {63'd0, (dmag != 8'd0)};
            else
                b_al = {56'd0, (dmag >> sh_r[2:0]) | {7'd0, |(dmag & lost_mask)}};
        end
    end

    // normalisation step
    logic need_right, big_right, need_left, big_left, norm_done;
    assign need_right = (m_reg[63:54] != 10'd0) || (e_reg < dttd_pkg::EXP_MIN);
    assign big_right  = (m_reg[63:62] != 2'd0) || (e_reg < dttd_pkg::EXP_MIN - 13'sd7);
    assign need_left  = !need_right && !m_reg[53] && (m_reg != 64'd0)
                        && (e_reg > dttd_pkg::EXP_MIN);
    assign big_left   = (m_reg[53:46] == 8'd0) && (e_reg > dttd_pkg::EXP_MIN + 13'sd7);
    assign norm_done  = pass_reg || (m_reg == 64'd0) || (!need_right && !need_left);

    // round and pack
    logic signed [12:0] bexp;
    logic [10:0]        field;
    logic [62:0]        rnd;
    logic               ovf, up;
    logic [63:0]        packed_val;
    assign bexp  = e_reg + dttd_pkg::EXP_PACK;
    assign ovf   = m_reg[53] && (bexp >= dttd_pkg::EXP_FIELD_MAX);
    assign field = m_reg[53] ? bexp[10:0] : 11'd0;
    assign up    = m_reg[0] && (sticky_reg || m_reg[1]);
    assign rnd   = {field, m_reg[52:1]} + {62'd0, up};
    always_comb
    begin
        if (pass_reg)
            packed_val = acc_reg;
        else if (m_reg == 64'd0)
            packed_val = {sign_reg, 63'd0};
        else if (ovf)
            packed_val = {sign_reg, dttd_pkg::EXP_ALL_ONES, 52'd0};
        else
            packed_val = {sign_reg, rnd};
    end

    // one radix-256 chunk of restoring division by ten
    logic [63:0] n_step;
    logic [3:0]  rem_step;
    always_comb
    begin
        logic [4:0] r5;
        logic       qb;
        n_step   = n_reg;
        rem_step = rem_reg;
        for (int i = 0; i < 8; i++)
        begin
            r5 = {rem_step, n_step[63]};
            qb = (r5 >= {1'b0, dttd_pkg::RADIX});
            rem_step = qb ? 4'(r5 - {1'b0, dttd_pkg::RADIX}) : r5[3:0];
            n_step   = {n_step[62:0], qb};
        end
    end

    // add or subtract magnitudes
    logic [63:0] sum_m;
    logic        sum_s;
    always_comb
    begin
        if (sa_reg == sb_reg)
        begin
            sum_m = a_reg + b_reg;
            sum_s = sa_reg;
        end
        else if (a_reg >= b_reg)
        begin
            sum_m = a_reg - b_reg;
            sum_s = sa_reg;
        end
        else
        begin
            sum_m = b_reg - a_reg;
            sum_s = sb_reg;
        end
        if (sum_m == 64'd0)
            sum_s = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= 64'd0;
            frac_exp_reg  <= 16'd0;
            wr_exp_reg    <= 16'd0;
            in_exp_reg    <= 1'b0;
            in_frac_reg   <= 1'b0;
            neg_reg       <= 1'b0;
            exp_neg_reg   <= 1'b0;
            count_reg     <= 16'd0;
            up_reg        <= 1'b0;
            chunk_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.char_take)
            begin
                if (is_minus)
                begin
                    if (in_exp_reg)
                        exp_neg_reg <= 1'b1;
                    else
                        neg_reg <= 1'b1;
                end
                else if (is_point)
                    in_frac_reg <= 1'b1;
                else if (is_exp)
                begin
                    in_frac_reg <= 1'b0;
                    in_exp_reg  <= 1'b1;
                end
                else if (is_other)
                begin
                    if (in_exp_reg)
                        wr_exp_reg <= exp_neg_reg ? wr_x10 - d16 : wr_x10 + d16;
                    else if (in_frac_reg)
                        frac_exp_reg <= frac_exp_reg - 16'd1;
                end
            end
            if (cmd.end_take)
            begin
                up_reg    <= !total[15];
                count_reg <= total[15] ? (~total + 16'd1) : total;
            end
            if (cmd.count_dec)
                count_reg <= count_reg - 16'd1;
            if (cmd.div_load)
                chunk_reg <= 3'd0;
            else if (cmd.div_step)
                chunk_reg <= chunk_reg + 3'd1;
            if (cmd.pack)
                acc_reg <= packed_val;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= 64'd0;
                frac_exp_reg  <= 16'd0;
                wr_exp_reg    <= 16'd0;
                in_exp_reg    <= 1'b0;
                in_frac_reg   <= 1'b0;
                neg_reg       <= 1'b0;
                exp_neg_reg   <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.char_take && is_other && !in_exp_reg)
            digit_reg <= digit9;
        if (cmd.out_load)
            result_reg <= acc_reg ^ {neg_reg, 63'd0};
        if (cmd.mul_load)
        begin
            m_reg      <= (q64 << 3) + (q64 << 1);
            e_reg      <= eq;
            sticky_reg <= 1'b0;
            sign_reg   <= acc_reg[63];
            pass_reg   <= acc_inf;
        end
        else if (cmd.div_load)
        begin
            n_reg    <= {3'd0, q, 8'd0};
            rem_reg  <= 4'd0;
            e_reg    <= eq - dttd_pkg::DIV_GUARD;
            sign_reg <= acc_reg[63];
            pass_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            n_reg   <= n_step;
            rem_reg <= rem_step;
        end
        else if (cmd.div_finish)
        begin
            m_reg      <= n_reg;
            sticky_reg <= (rem_reg != 4'd0);
        end
        else if (cmd.align)
        begin
            a_reg    <= a_al;
            b_reg    <= b_al;
            sa_reg   <= acc_reg[63];
            sb_reg   <= sd_al;
            e_reg    <= e_al;
            pass_reg <= acc_inf;
        end
        else if (cmd.addsub)
        begin
            m_reg      <= sum_m;
            sign_reg   <= sum_s;
            sticky_reg <= 1'b0;
        end
        else if (cmd.norm_step)
        begin
            if (need_right)
            begin
                if (big_right)
                begin
                    m_reg      <= m_reg >> 8;
                    sticky_reg <= sticky_reg || (m_reg[7:0] != 8'd0);
                    e_reg      <= e_reg + 13'sd8;
                end
                else
                begin
                    m_reg      <= m_reg >> 1;
                    sticky_reg <= sticky_reg || m_reg[0];
                    e_reg      <= e_reg + 13'sd1;
                end
            end
            else if (big_left)
            begin
                m_reg <= m_reg << 8;
                e_reg <= e_reg - 13'sd8;
            end
            else
            begin
                m_reg <= m_reg << 1;
                e_reg <= e_reg - 13'sd1;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_bits = result_reg;

    assign sts.mant_digit  = is_other && !in_exp_reg;
    assign sts.end_item    = end_of_string;
    assign sts.norm_done   = norm_done;
    assign sts.div_last    = (chunk_reg == 3'd7);
    assign sts.count_zero  = (count_reg == 16'd0);
    assign sts.acc_special = acc_zero || acc_inf;
    assign sts.scale_up    = up_reg;
    assign sts.out_full    = out_valid_reg && !out_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten while waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        !((acc_reg[62:52] == dttd_pkg::EXP_ALL_ONES) && (acc_reg[51:0] != 52'd0)))
        else $error("accumulator holds a NaN");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (acc_reg == 64'd0) && (frac_exp_reg == 16'd0)
                         && (wr_exp_reg == 16'd0) && !neg_reg)
        else $error("state not cleared after end item");

endmodule
